@@ src/rc4_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher unit: sizes, register
// indexes, operation codes and the controller state type.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int PERM_SIZE     = 256;
  localparam int PERM_ADDR_W   = $clog2(PERM_SIZE);
  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int NUM_KEY_WORDS = 4;
  localparam int KEY_WORD_W    = 64;
  localparam int KEY_LEN_W     = 6;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = KEY_WORD_W;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;

  localparam logic OP_REKEY   = 1'b0;
  localparam logic OP_ENCRYPT = 1'b1;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(MAX_KEY_BYTES);
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(1);

  typedef logic [PERM_ADDR_W-1:0] perm_addr_t;
  typedef logic [7:0]             byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_J,
    ST_ENC_SWAP,
    ST_ENC_T,
    ST_ENC_OUT,
    ST_KS_N,
    ST_KS_J,
    ST_KS_SWAP
  } state_t;

endpackage

@@ src/rc4_stream_cipher_unit.sv @@
// Encrypt item: ST_ENC_J, ST_ENC_SWAP, ST_ENC_T and ST_ENC_OUT follow the input transfer;
// no new byte is taken before ST_ENC_OUT registers the result, as the permutation memory
// has one write and one read port (read S[i], read S[j], two writes, read S[t]).
// Rekey item: each key schedule step runs ST_KS_N, ST_KS_J and ST_KS_SWAP; no result.
// Reset restores the identity permutation at once through per-entry valid bits,
// zeroes both indices and key words, and sets the key length to 1.
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 byte cipher: key schedule and keystream generation over a 256-entry
// permutation kept in a synchronous memory with one read and one write port.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte
);
  import rc4_pkg::*;

  // configuration
  logic [KEY_WORD_W-1:0] key_word [NUM_KEY_WORDS];
  logic [KEY_LEN_W-1:0]  key_length;
  logic [KEY_LEN_W-1:0]  key_len_eff;

  // permutation memory
  byte_t      perm_mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] perm_valid;
  logic       rd_en;
  perm_addr_t rd_addr;
  byte_t      rd_data;
  logic       wr_en;
  perm_addr_t wr_addr;
  byte_t      wr_data;
  logic       perm_clear;

  // control and datapath registers
  state_t     state, state_next;
  perm_addr_t index_i, index_i_next;
  perm_addr_t index_j, index_j_next;
  perm_addr_t ks_n, ks_n_next;
  perm_addr_t ks_j, ks_j_next;
  logic [KEY_IDX_W-1:0] key_idx, key_idx_next;
  byte_t      hold, hold_next;
  perm_addr_t t_addr, t_addr_next;
  byte_t      data_byte, data_byte_next;
  logic       out_valid_next;
  byte_t      out_byte_next;

  // last key schedule step: its pending write goes out on the way back to idle
  logic ks_tail;

  logic  accept;
  logic  out_free;
  byte_t key_byte;
  perm_addr_t ks_j_sum;

  always_comb begin
    key_len_eff = key_length;
    if (key_length == '0) begin
      key_len_eff = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_MAX) begin
      key_len_eff = KEY_LEN_MAX;
    end
  end

  assign key_byte = key_word[key_idx[KEY_IDX_W-1:3]][{key_idx[2:0], 3'b000} +: 8];
  assign ks_j_sum = ks_j + key_byte + rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_KEY_WORDS; w++) begin
        key_word[w] <= '0;
      end
      key_length <= KEY_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_WORD_0: key_word[0] <= cfg_data;
        REG_KEY_WORD_1: key_word[1] <= cfg_data;
        REG_KEY_WORD_2: key_word[2] <= cfg_data;
        REG_KEY_WORD_3: key_word[3] <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // entries not written since the last clear read as their own index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else if (perm_valid[rd_addr]) begin
        rd_data <= perm_mem[rd_addr];
      end else begin
        rd_data <= rd_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || perm_clear) begin
      perm_valid <= '0;
    end else if (wr_en) begin
      perm_valid[wr_addr] <= 1'b1;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == ST_IDLE || (state == ST_ENC_OUT && out_free));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    index_i_next   = index_i;
    index_j_next   = index_j;
    ks_n_next      = ks_n;
    ks_j_next      = ks_j;
    key_idx_next   = key_idx;
    hold_next      = hold;
    t_addr_next    = t_addr;
    data_byte_next = data_byte;
    out_valid_next = out_valid && out_stall;
    out_byte_next  = out_byte;
    rd_en          = 1'b0;
    rd_addr        = index_i;
    wr_en          = 1'b0;
    wr_addr        = index_i;
    wr_data        = rd_data;
    perm_clear     = 1'b0;

    unique case (state)
      ST_IDLE, ST_ENC_OUT: begin
        // closing swap write of the key schedule, forwarded to a same-cycle read
        wr_en   = ks_tail;
        wr_addr = ks_j;
        wr_data = hold;
        if (state == ST_ENC_OUT) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_byte_next  = data_byte ^ rd_data;
            state_next     = ST_IDLE;
          end
        end
        if (accept) begin
          if (opcode == OP_ENCRYPT) begin
            index_i_next   = index_i + 1'b1;
            rd_en          = 1'b1;
            rd_addr        = index_i + 1'b1;
            data_byte_next = in_byte;
            state_next     = ST_ENC_J;
          end else begin
            perm_clear   = 1'b1;
            index_i_next = '0;
            index_j_next = '0;
            ks_n_next    = '0;
            ks_j_next    = '0;
            key_idx_next = '0;
            state_next   = ST_KS_N;
          end
        end
      end
      ST_ENC_J: begin
        hold_next    = rd_data;
        index_j_next = index_j + rd_data;
        rd_en        = 1'b1;
        rd_addr      = index_j + rd_data;
        state_next   = ST_ENC_SWAP;
      end
      ST_ENC_SWAP: begin
        wr_en       = 1'b1;
        wr_addr     = index_i;
        wr_data     = rd_data;
        t_addr_next = hold + rd_data;
        state_next  = ST_ENC_T;
      end
      ST_ENC_T: begin
        wr_en      = 1'b1;
        wr_addr    = index_j;
        wr_data    = hold;
        rd_en      = 1'b1;
        rd_addr    = t_addr;
        state_next = ST_ENC_OUT;
      end
      ST_KS_N: begin
        // second half of the previous step's swap, overlapped with this read
        wr_en      = (ks_n != '0);
        wr_addr    = ks_j;
        wr_data    = hold;
        rd_en      = 1'b1;
        rd_addr    = ks_n;
        state_next = ST_KS_J;
      end
      ST_KS_J: begin
        hold_next  = rd_data;
        ks_j_next  = ks_j_sum;
        rd_en      = 1'b1;
        rd_addr    = ks_j_sum;
        state_next = ST_KS_SWAP;
      end
      ST_KS_SWAP: begin
        wr_en     = 1'b1;
        wr_addr   = ks_n;
        wr_data   = rd_data;
        ks_n_next = ks_n + 1'b1;
        if ({1'b0, key_idx} == key_len_eff - 1'b1) begin
          key_idx_next = '0;
        end else begin
          key_idx_next = key_idx + 1'b1;
        end
        // wrap of the step counter leaves the last write for the final pass
        state_next = ST_KS_N;
        if (ks_n == perm_addr_t'(PERM_SIZE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      index_i   <= '0;
      index_j   <= '0;
      out_valid <= 1'b0;
      ks_tail   <= 1'b0;
    end else begin
      state     <= state_next;
      index_i   <= index_i_next;
      index_j   <= index_j_next;
      out_valid <= out_valid_next;
      ks_tail   <= (state == ST_KS_SWAP) && (ks_n == perm_addr_t'(PERM_SIZE - 1));
    end
  end

  always_ff @(posedge clk) begin
    ks_n      <= ks_n_next;
    ks_j      <= ks_j_next;
    key_idx   <= key_idx_next;
    hold      <= hold_next;
    t_addr    <= t_addr_next;
    data_byte <= data_byte_next;
    out_byte  <= out_byte_next;
  end

endmodule

@@ verif/rc4_cipher_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc4_cipher_monitor
// Watches the register port and both channels of the RC4 unit, keeps its own
// permutation, indices and key registers, predicts every encrypt result and
// compares each output transfer with the oldest pending prediction.
// ----------------------------------------------------------------------------
module rc4_cipher_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rc4_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            opcode,
  input  logic [7:0]                      in_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_byte,
  output int                              pending,
  output int                              errors
);
  import rc4_pkg::*;

  byte_t                 perm [PERM_SIZE];
  byte_t                 idx_i;
  byte_t                 idx_j;
  logic [KEY_WORD_W-1:0] key_words [NUM_KEY_WORDS];
  logic [KEY_LEN_W-1:0]  key_len;
  byte_t                 cipher_out_q [$];
  int                    err_total = 0;

  task automatic restore_identity();
    for (int n = 0; n < PERM_SIZE; n++) perm[n] = byte_t'(n);
  endtask

  // standard key schedule over the configured key bytes
  task automatic rebuild_perm();
    int    len;
    int    k;
    byte_t j;
    byte_t kb;
    byte_t tmp;
    len = int'(key_len);
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    restore_identity();
    j = '0;
    for (int n = 0; n < PERM_SIZE; n++) begin
      k = n % len;
      kb = key_words[k / 8][8 * (k % 8) +: 8];
      j = j + kb + perm[n];
      tmp = perm[n];
      perm[n] = perm[j];
      perm[j] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
  endtask

  function automatic byte_t next_keystream();
    byte_t tmp;
    byte_t t;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    tmp = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = tmp;
    t = perm[idx_i] + perm[idx_j];
    return perm[t];
  endfunction

  always @(posedge clk) begin
    byte_t exp_byte;
    if (rst) begin
      restore_identity();
      idx_i = '0;
      idx_j = '0;
      for (int w = 0; w < NUM_KEY_WORDS; w++) key_words[w] = '0;
      key_len = KEY_LEN_RESET;
      cipher_out_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_out_q.size() == 0) begin
          $error("out_byte transfer with no result pending, actual %02h", out_byte);
          err_total++;
        end else begin
          exp_byte = cipher_out_q.pop_front();
          if (out_byte !== exp_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h", exp_byte, out_byte);
            err_total++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
            key_words[cfg_index[1:0]] = cfg_data;
          end
          REG_KEY_LENGTH: begin
            key_len = cfg_data[KEY_LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_REKEY) rebuild_perm();
        else cipher_out_q.push_back(in_byte ^ next_keystream());
      end
    end
    pending <= cipher_out_q.size();
    errors  <= err_total;
  end

endmodule

@@ verif/rc4_stream_cipher_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit_tb
// Drives the RC4 unit with directed and random rekey and encrypt items under
// several key settings and idle/stall mixes; the monitor predicts and checks.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit_tb;
  import rc4_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES   = 1000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_LIMIT     = 100000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   opcode;
  logic [7:0]             in_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic [7:0]             out_byte;
  logic                   start_hold;

  int pending;
  int errors;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;

  rc4_stream_cipher_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
  );

  rc4_cipher_monitor u_monitor (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("rc4_stream_cipher_unit test failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off after a start_hold pulse
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (start_hold) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(input logic op, input byte_t b);
    in_valid <= 1'b1;
    opcode   <= op;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic wait_results();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_key(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3,
                             input logic [63:0] len_word, input bit junk);
    write_reg(REG_KEY_WORD_0, w0);
    write_reg(REG_KEY_WORD_1, w1);
    write_reg(REG_KEY_WORD_2, w2);
    write_reg(REG_KEY_WORD_3, w3);
    write_reg(REG_KEY_LENGTH, len_word);
    // indexes past the register list must be ignored
    if (junk) begin
      for (int r = int'(REG_KEY_LENGTH) + 1; r < 2 ** CFG_INDEX_W; r++)
        write_reg(CFG_INDEX_W'(r), rand64());
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_random_key();
    logic [63:0]          len_word;
    logic [KEY_LEN_W-1:0] len;
    int                   pick;
    pick = $urandom_range(9);
    case (pick)
      0:       len = '0;
      1:       len = KEY_LEN_W'($urandom_range(63, 33));
      2:       len = KEY_LEN_MAX;
      3:       len = KEY_LEN_RESET;
      default: len = KEY_LEN_W'($urandom_range(MAX_KEY_BYTES, 1));
    endcase
    len_word = rand64();
    len_word[KEY_LEN_W-1:0] = len;
    program_key(rand64(), rand64(), rand64(), rand64(), len_word, $urandom_range(3) == 0);
  endtask

  initial begin
    logic [63:0] len_word;
    int          waited;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = OP_REKEY;
    in_byte    = '0;
    start_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // identity permutation before any rekey
    send_item(OP_ENCRYPT, 8'h00);
    send_item(OP_ENCRYPT, 8'hFF);
    send_item(OP_ENCRYPT, 8'h55);
    send_item(OP_ENCRYPT, 8'hAA);
    // reset key: one zero byte
    send_item(OP_REKEY, 8'hFF);
    send_item(OP_ENCRYPT, 8'h00);
    send_item(OP_ENCRYPT, 8'hFF);
    // back-to-back rekeys
    send_item(OP_REKEY, 8'h00);
    send_item(OP_REKEY, 8'hA5);
    send_item(OP_ENCRYPT, 8'h3C);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // all-ones key at full length
    len_word = '1;
    len_word[KEY_LEN_W-1:0] = KEY_LEN_MAX;
    program_key('1, '1, '1, '1, len_word, 1'b0);
    send_item(OP_REKEY, 8'h00);
    send_item(OP_ENCRYPT, 8'h00);
    send_item(OP_ENCRYPT, 8'hFF);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // zero length acts as one byte
    len_word = rand64();
    len_word[KEY_LEN_W-1:0] = '0;
    program_key(rand64(), rand64(), rand64(), rand64(), len_word, 1'b0);
    send_item(OP_REKEY, byte_t'($urandom()));
    send_item(OP_ENCRYPT, byte_t'($urandom()));
    send_item(OP_ENCRYPT, byte_t'($urandom()));
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // oversize length saturates, plus writes past the register list
    len_word = rand64();
    len_word[KEY_LEN_W-1:0] = '1;
    program_key(rand64(), rand64(), rand64(), rand64(), len_word, 1'b1);
    send_item(OP_REKEY, byte_t'($urandom()));
    send_item(OP_ENCRYPT, byte_t'($urandom()));
    send_item(OP_ENCRYPT, byte_t'($urandom()));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 85; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 85; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      program_random_key();
      // long receiver hold-off so the unit fills and stalls its input
      if (ph % 4 == 0) begin
        start_hold <= 1'b1;
        @(posedge clk);
        start_hold <= 1'b0;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((n == 0) ? ($urandom_range(9) < 7) : ($urandom_range(99) < 4))
          send_item(OP_REKEY, byte_t'($urandom()));
        else
          send_item(OP_ENCRYPT, byte_t'($urandom()));
        if ($urandom_range(99) == 0) wait_results();
      end
    end

    if (in_valid) in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending == 0 && errors == 0) begin
      $display("rc4_stream_cipher_unit test passed");
    end else begin
      $display("rc4_stream_cipher_unit test failed");
    end
    $finish;
  end

endmodule
